// File: rtl/core/lmcd_pkg.sv
// Package for the LED matrix cascade driver: widths, register addresses,
// operation and state codes, and the controller/datapath command and status structs.
// No dependencies.
package lmcd_pkg;

  localparam int MAX_MATRICES = 8;
  localparam int ROWS         = 8;
  localparam int MAT_W        = $clog2(MAX_MATRICES);
  localparam int ROW_W        = $clog2(ROWS);
  localparam int MEM_AW       = MAT_W + ROW_W;
  localparam int OP_W         = 3;
  localparam int CHAIN_W      = 4;
  localparam int BRIGHT_W     = 4;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 4;

  localparam logic [ADDR_W-1:0] REG_DECODE     = 4'h9;
  localparam logic [ADDR_W-1:0] REG_INTENSITY  = 4'hA;
  localparam logic [ADDR_W-1:0] REG_SCAN_LIMIT = 4'hB;
  localparam logic [ADDR_W-1:0] REG_TEST       = 4'hF;
  localparam logic [ADDR_W-1:0] REG_SHUTDOWN   = 4'hC;

  localparam logic [DATA_W-1:0] DATA_ZERO       = 8'h00;
  localparam logic [DATA_W-1:0] SCAN_ALL        = 8'h07;
  localparam logic [DATA_W-1:0] SHUTDOWN_NORMAL = 8'h01;
  localparam logic [DATA_W-1:0] TEST_ENABLE     = 8'h01;

  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 4'd9;

  localparam logic [ROW_W-1:0] INIT_LAST_STEP = 3'd4;
  localparam logic [ROW_W-1:0] ROW_LAST       = ROW_W'(ROWS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_STORE    = 3'd0,
    OP_FLUSH    = 3'd1,
    OP_INIT     = 3'd2,
    OP_TEST_ON  = 3'd3,
    OP_TEST_OFF = 3'd4,
    OP_CLEAR    = 3'd5
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHAIN  = 2'd0,
    CFG_BRIGHT = 2'd1,
    CFG_INVERT = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_INIT,
    ST_TEST,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic              store;
    logic              issue;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              use_mem;
    logic [MEM_AW-1:0] rd_addr;
    logic              latch;
    logic              last;
  } dp_cmd_t;

  typedef struct packed {
    logic              slot_free;
    logic              chain_zero;
    logic [MAT_W-1:0]  last_matrix;
    logic [DATA_W-1:0] intensity;
    logic              invert;
  } dp_stat_t;

endpackage

// File: rtl/core/lmcd_in_if.sv
// Input channel of the LED matrix cascade driver: one operation word.
// Depends on lmcd_pkg.
interface lmcd_in_if;
  import lmcd_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [MAT_W-1:0] matrix_index;
  logic [ROW_W-1:0] row_index;
  logic [7:0]       row_bits;

  modport source (output valid, output operation, output matrix_index,
                  output row_index, output row_bits, input ready);
  modport sink   (input valid, input operation, input matrix_index,
                  input row_index, input row_bits, output ready);
endinterface

// File: rtl/core/lmcd_out_if.sv
// Output channel of the LED matrix cascade driver: one command word.
// Depends on lmcd_pkg.
interface lmcd_out_if;
  import lmcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] reg_address;
  logic [DATA_W-1:0] reg_data;
  logic              latch_after;
  logic              last;

  modport source (output valid, output reg_address, output reg_data,
                  output latch_after, output last, input ready);
  modport sink   (input valid, input reg_address, input reg_data,
                  input latch_after, input last, output ready);
endinterface

// File: rtl/core/led_matrix_cascade_driver_unit.sv
// Top level of the LED matrix cascade driver: controller plus datapath.
// Depends on lmcd_pkg, lmcd_in_if, lmcd_out_if, lmcd_controller, lmcd_datapath.
//
// Takes one operation word at a time and emits 12-bit (address plus data) command words, one per
// cycle while the sink keeps ready high. A store emits nothing; a flush
// emits 8*N words, init 5*N, clear 8 and test on/off one, with N the chain
// length saturated to 8 (zero chain: flush and init emit nothing). The
// sequencer produces one word per cycle while the output slot is free,
// through a single frame store read port and a one-word output register; a
// new operation is taken once the sequencer has handed its final word to that
// register. The frame store reads as zero after reset without a clearing pass.
module led_matrix_cascade_driver_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lmcd_in_if.sink                          in_i,
  lmcd_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [lmcd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lmcd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import lmcd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lmcd_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_op_i    (in_i.operation),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lmcd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .wr_matrix_i (in_i.matrix_index),
    .wr_row_i    (in_i.row_index),
    .wr_bits_i   (in_i.row_bits),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_addr_o  (out_o.reg_address),
    .out_data_o  (out_o.reg_data),
    .out_latch_o (out_o.latch_after),
    .out_last_o  (out_o.last)
  );

endmodule

// File: rtl/core/lmcd_datapath.sv
// Datapath of the LED matrix cascade driver: configuration registers, frame
// store with valid bits, and the output word register. Depends on lmcd_pkg.
module lmcd_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lmcd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lmcd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  lmcd_pkg::dp_cmd_t                cmd_i,
  output lmcd_pkg::dp_stat_t               stat_o,
  input  logic [lmcd_pkg::MAT_W-1:0]       wr_matrix_i,
  input  logic [lmcd_pkg::ROW_W-1:0]       wr_row_i,
  input  logic [7:0]                       wr_bits_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [lmcd_pkg::ADDR_W-1:0]      out_addr_o,
  output logic [lmcd_pkg::DATA_W-1:0]      out_data_o,
  output logic                             out_latch_o,
  output logic                             out_last_o
);
  import lmcd_pkg::*;

  localparam int DEPTH = MAX_MATRICES * ROWS;

  logic [CHAIN_W-1:0]  chain_q;
  logic [BRIGHT_W-1:0] bright_q;
  logic                invert_q;

  logic [7:0]          mem [DEPTH];
  logic [DEPTH-1:0]    valid_q;
  logic [MEM_AW-1:0]   wr_addr;

  logic [7:0]          rd_data_q;
  logic                rd_vld_q;
  logic                out_valid_q;
  logic [ADDR_W-1:0]   out_addr_q;
  logic [DATA_W-1:0]   out_const_q;
  logic                out_use_mem_q;
  logic                out_inv_q;
  logic                out_latch_q;
  logic                out_last_q;

  logic [7:0]          mem_byte;
  logic [BRIGHT_W-1:0] bright_clamped;

  function automatic logic [7:0] bit_reverse(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  assign wr_addr = {wr_matrix_i, wr_row_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q  <= CHAIN_W'(1);
      bright_q <= '0;
      invert_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CHAIN:  chain_q  <= cfg_data_i;
        CFG_BRIGHT: bright_q <= cfg_data_i;
        CFG_INVERT: invert_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.store) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem[wr_addr] <= wr_bits_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_data_q <= mem[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (cmd_i.issue) begin
      rd_vld_q <= valid_q[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.issue) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      out_addr_q    <= cmd_i.addr;
      out_const_q   <= cmd_i.data;
      out_use_mem_q <= cmd_i.use_mem;
      out_inv_q     <= invert_q;
      out_latch_q   <= cmd_i.latch;
      out_last_q    <= cmd_i.last;
    end
  end

  assign mem_byte = rd_vld_q ? rd_data_q : 8'h00;
  assign bright_clamped = (bright_q > BRIGHT_MAX) ? BRIGHT_MAX : bright_q;

  assign out_valid_o = out_valid_q;
  assign out_addr_o  = out_addr_q;
  assign out_data_o  = !out_use_mem_q ? out_const_q :
                       (out_inv_q ? bit_reverse(mem_byte) : mem_byte);
  assign out_latch_o = out_latch_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    stat_o.slot_free  = !out_valid_q || out_ready_i;
    stat_o.chain_zero = (chain_q == '0);
    if (chain_q >= CHAIN_W'(MAX_MATRICES)) begin
      stat_o.last_matrix = MAT_W'(MAX_MATRICES - 1);
    end else begin
      stat_o.last_matrix = MAT_W'(chain_q - CHAIN_W'(1));
    end
    stat_o.intensity = DATA_W'(bright_clamped);
    stat_o.invert    = invert_q;
  end

endmodule

// File: rtl/core/lmcd_controller.sv
// Controller of the LED matrix cascade driver: operation decode and the word
// sequencer for flush, init, test and clear runs. Depends on lmcd_pkg.
module lmcd_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lmcd_pkg::OP_W-1:0]   in_op_i,
  input  lmcd_pkg::dp_stat_t          stat_i,
  output lmcd_pkg::dp_cmd_t           cmd_o
);
  import lmcd_pkg::*;

  state_e           state_q, state_d;
  logic [ROW_W-1:0] grp_q, grp_d;
  logic [MAT_W-1:0] idx_q, idx_d;
  logic             test_on_q, test_on_d;

  logic             accept;
  logic             at_last_mat;
  logic [MAT_W-1:0] rd_matrix;
  logic [ROW_W-1:0] rd_row;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign at_last_mat = (idx_q == stat_i.last_matrix);
  assign rd_matrix   = stat_i.invert ? MAT_W'(stat_i.last_matrix - idx_q) : idx_q;
  assign rd_row      = stat_i.invert ? ROW_W'(ROW_LAST - grp_q) : grp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      grp_q     <= '0;
      idx_q     <= '0;
      test_on_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      grp_q     <= grp_d;
      idx_q     <= idx_d;
      test_on_q <= test_on_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    grp_d     = grp_q;
    idx_d     = idx_q;
    test_on_d = test_on_q;
    case (state_q)
      ST_IDLE: begin
        grp_d = '0;
        idx_d = '0;
        if (accept) begin
          case (op_e'(in_op_i))
            OP_FLUSH:    if (!stat_i.chain_zero) state_d = ST_FLUSH;
            OP_INIT:     if (!stat_i.chain_zero) state_d = ST_INIT;
            OP_TEST_ON: begin
              state_d   = ST_TEST;
              test_on_d = 1'b1;
            end
            OP_TEST_OFF: begin
              state_d   = ST_TEST;
              test_on_d = 1'b0;
            end
            OP_CLEAR:    state_d = ST_CLEAR;
            default: ;
          endcase
        end
      end
      ST_FLUSH, ST_INIT: begin
        if (cmd_o.issue) begin
          if (cmd_o.last) begin
            state_d = ST_IDLE;
          end else if (at_last_mat) begin
            idx_d = '0;
            grp_d = grp_q + ROW_W'(1);
          end else begin
            idx_d = idx_q + MAT_W'(1);
          end
        end
      end
      ST_CLEAR: begin
        if (cmd_o.issue) begin
          if (cmd_o.last) begin
            state_d = ST_IDLE;
          end else begin
            grp_d = grp_q + ROW_W'(1);
          end
        end
      end
      ST_TEST: begin
        if (cmd_o.issue) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.store   = accept && (op_e'(in_op_i) == OP_STORE);
    cmd_o.issue   = (state_q != ST_IDLE) && stat_i.slot_free;
    cmd_o.addr    = ADDR_W'(grp_q) + ADDR_W'(1);
    cmd_o.data    = DATA_ZERO;
    cmd_o.use_mem = 1'b0;
    cmd_o.rd_addr = {rd_matrix, rd_row};
    cmd_o.latch   = 1'b1;
    cmd_o.last    = 1'b0;
    case (state_q)
      ST_FLUSH: begin
        cmd_o.use_mem = 1'b1;
        cmd_o.latch   = at_last_mat;
        cmd_o.last    = at_last_mat && (grp_q == ROW_LAST);
      end
      ST_INIT: begin
        cmd_o.last = at_last_mat && (grp_q == INIT_LAST_STEP);
        case (grp_q)
          3'd0: begin
            cmd_o.addr = REG_DECODE;
            cmd_o.data = DATA_ZERO;
          end
          3'd1: begin
            cmd_o.addr = REG_INTENSITY;
            cmd_o.data = stat_i.intensity;
          end
          3'd2: begin
            cmd_o.addr = REG_SCAN_LIMIT;
            cmd_o.data = SCAN_ALL;
          end
          3'd3: begin
            cmd_o.addr = REG_TEST;
            cmd_o.data = DATA_ZERO;
          end
          default: begin
            cmd_o.addr = REG_SHUTDOWN;
            cmd_o.data = SHUTDOWN_NORMAL;
          end
        endcase
      end
      ST_TEST: begin
        cmd_o.addr = REG_TEST;
        cmd_o.data = test_on_q ? TEST_ENABLE : DATA_ZERO;
        cmd_o.last = 1'b1;
      end
      ST_CLEAR: begin
        cmd_o.last = (grp_q == ROW_LAST);
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.issue && cmd_o.last) |=> (state_q == ST_IDLE))
    else $error("run did not end after its final word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> (grp_q <= INIT_LAST_STEP))
    else $error("init step counter out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> !cmd_o.store)
    else $error("frame store written during a run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TEST) |-> (cmd_o.last && cmd_o.latch))
    else $error("test word not marked final and latched");
`endif

endmodule

// File: bench/tb_led_matrix_cascade_driver_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for led_matrix_cascade_driver_unit: a directed stimulus table, then
// random phases under several register settings, every command word checked in order.
// Depends on lmcd_pkg, lmcd_in_if, lmcd_out_if and the RTL of the driver.
module tb_led_matrix_cascade_driver_unit;
  import lmcd_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam int RAND_PHASES   = 6;
  localparam int OPS_PER_PHASE = 35;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              latch;
    logic              last;
  } cmd_word_t;

  typedef struct packed {
    logic                is_cfg;
    logic [OP_W-1:0]     op;
    logic [MAT_W-1:0]    mat;
    logic [ROW_W-1:0]    row;
    logic [7:0]          bits;
    logic                typed;
    logic [ADDR_W-1:0]   t_addr;
    logic [DATA_W-1:0]   t_data;
    logic [CHAIN_W-1:0]  chain;
    logic [BRIGHT_W-1:0] bright;
    logic                invert;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lmcd_in_if  in_ch ();
  lmcd_out_if out_ch ();

  led_matrix_cascade_driver_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  cmd_word_t           pending_words[$];
  cmd_word_t           want_word;
  stim_row_t           stim_rows[$];
  logic [7:0]          frame_mirror[MAX_MATRICES*ROWS];
  logic [CHAIN_W-1:0]  chain_cfg;
  logic [BRIGHT_W-1:0] bright_cfg;
  logic                invert_cfg;
  int                  errors;
  int                  words_seen;
  int                  ops_sent;
  int                  flushes_sent;
  int                  inits_sent;
  int                  settings_used;
  int                  cycles;
  bit                  src_fast;
  bit                  sink_fast;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still due", cycles, pending_words.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input int want, input int got);
    $display("Mismatch at word %0d, %s: expected 0x%0h, got 0x%0h", words_seen, field, want, got);
    errors++;
  endtask

  task automatic predict_cmds(input logic [OP_W-1:0] op, input logic [MAT_W-1:0] mat,
                              input logic [ROW_W-1:0] row, input logic [7:0] bits);
    cmd_word_t         run[$];
    logic [ADDR_W-1:0] init_addr[5];
    logic [DATA_W-1:0] init_data[5];
    logic [7:0]        v;
    int                n;
    int                r;
    int                i;
    int                s;
    n = (chain_cfg > MAX_MATRICES) ? MAX_MATRICES : int'(chain_cfg);
    init_addr = '{REG_DECODE, REG_INTENSITY, REG_SCAN_LIMIT, REG_TEST, REG_SHUTDOWN};
    init_data = '{DATA_ZERO, DATA_ZERO, SCAN_ALL, DATA_ZERO, SHUTDOWN_NORMAL};
    init_data[1] = (bright_cfg > BRIGHT_MAX) ? DATA_W'(BRIGHT_MAX) : DATA_W'(bright_cfg);
    case (op)
      OP_STORE: frame_mirror[{mat, row}] = bits;
      OP_FLUSH: begin
        for (r = 0; r < ROWS; r++) begin
          for (i = 0; i < n; i++) begin
            if (invert_cfg) begin
              v = frame_mirror[(n - 1 - i) * ROWS + (ROWS - 1 - r)];
              v = {<<{v}};
            end else begin
              v = frame_mirror[i * ROWS + r];
            end
            run.push_back('{ADDR_W'(r + 1), v, (i == n - 1), 1'b0});
          end
        end
      end
      OP_INIT: begin
        for (s = 0; s < 5; s++) begin
          for (i = 0; i < n; i++) run.push_back('{init_addr[s], init_data[s], 1'b1, 1'b0});
        end
      end
      OP_TEST_ON:  run.push_back('{REG_TEST, TEST_ENABLE, 1'b1, 1'b0});
      OP_TEST_OFF: run.push_back('{REG_TEST, DATA_ZERO, 1'b1, 1'b0});
      OP_CLEAR: begin
        for (i = 1; i <= ROWS; i++) run.push_back('{ADDR_W'(i), DATA_ZERO, 1'b1, 1'b0});
      end
      default: ;
    endcase
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[k]) pending_words.push_back(run[k]);
  endtask

  function automatic stim_row_t op_row(input logic [OP_W-1:0] op,
                                       input logic [MAT_W-1:0] mat = '0,
                                       input logic [ROW_W-1:0] row = '0,
                                       input logic [7:0] bits = '0);
    stim_row_t r;
    r      = '0;
    r.op   = op;
    r.mat  = mat;
    r.row  = row;
    r.bits = bits;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [OP_W-1:0] op,
                                          input logic [ADDR_W-1:0] addr,
                                          input logic [DATA_W-1:0] data);
    stim_row_t r;
    r        = op_row(op);
    r.typed  = 1'b1;
    r.t_addr = addr;
    r.t_data = data;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CHAIN_W-1:0] chain,
                                        input logic [BRIGHT_W-1:0] bright,
                                        input logic invert);
    stim_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.chain  = chain;
    r.bright = bright;
    r.invert = invert;
    return r;
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t r;
    int        pick;
    r      = '0;
    pick   = $urandom_range(0, 99);
    r.mat  = MAT_W'($urandom_range(0, MAX_MATRICES - 1));
    r.row  = ROW_W'($urandom_range(0, ROWS - 1));
    r.bits = 8'($urandom_range(0, 255));
    if (pick < 55) r.op = OP_STORE;
    else if (pick < 70) r.op = OP_FLUSH;
    else if (pick < 77) r.op = OP_INIT;
    else if (pick < 83) r.op = OP_TEST_ON;
    else if (pick < 89) r.op = OP_TEST_OFF;
    else if (pick < 95) r.op = OP_CLEAR;
    else r.op = pick[0] ? OP_SPARE_6 : OP_SPARE_7;
    return r;
  endfunction

  task automatic send_op(input stim_row_t r);
    int gap;
    gap = src_fast ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= r.op;
    in_ch.matrix_index <= r.mat;
    in_ch.row_index    <= r.row;
    in_ch.row_bits     <= r.bits;
    do @(posedge clk); while (!in_ch.ready);
    ops_sent++;
    if (r.op == OP_FLUSH) flushes_sent++;
    if (r.op == OP_INIT) inits_sent++;
    if (r.typed) pending_words.push_back('{r.t_addr, r.t_data, 1'b1, 1'b1});
    else predict_cmds(r.op, r.mat, r.row, r.bits);
  endtask

  // hold valid low until every due word is out
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  task automatic set_config(input logic [CHAIN_W-1:0] chain,
                            input logic [BRIGHT_W-1:0] bright, input logic invert);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CHAIN;
    cfg_data  <= CFG_DATA_W'(chain);
    @(posedge clk);
    cfg_index <= CFG_BRIGHT;
    cfg_data  <= CFG_DATA_W'(bright);
    @(posedge clk);
    cfg_index <= CFG_INVERT;
    cfg_data  <= CFG_DATA_W'(invert);
    @(posedge clk);
    cfg_we     <= 1'b0;
    chain_cfg  = chain;
    bright_cfg = bright;
    invert_cfg = invert;
    settings_used++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", 0, {out_ch.reg_address, out_ch.reg_data});
      end else begin
        want_word = pending_words.pop_front();
        if (out_ch.reg_address !== want_word.addr)
          report_mismatch("reg_address", want_word.addr, out_ch.reg_address);
        if (out_ch.reg_data !== want_word.data)
          report_mismatch("reg_data", want_word.data, out_ch.reg_data);
        if (out_ch.latch_after !== want_word.latch)
          report_mismatch("latch_after", want_word.latch, out_ch.latch_after);
        if (out_ch.last !== want_word.last)
          report_mismatch("last", want_word.last, out_ch.last);
      end
    end
  end

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = sink_fast ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid || !out_ch.ready);
    end
  end

  initial begin
    stim_row_t           row;
    logic [CHAIN_W-1:0]  chain;
    int                  counted;
    bit                  paused;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= OP_STORE;
    in_ch.matrix_index <= '0;
    in_ch.row_index    <= '0;
    in_ch.row_bits     <= '0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_CHAIN;
    cfg_data           <= '0;
    rst_n              <= 1'b0;
    chain_cfg  = CHAIN_W'(1);
    bright_cfg = '0;
    invert_cfg = 1'b0;
    foreach (frame_mirror[k]) frame_mirror[k] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    stim_rows.push_back(typed_row(OP_TEST_ON, REG_TEST, TEST_ENABLE));
    stim_rows.push_back(typed_row(OP_TEST_OFF, REG_TEST, DATA_ZERO));
    stim_rows.push_back(op_row(OP_FLUSH));
    stim_rows.push_back(op_row(OP_INIT));
    stim_rows.push_back(op_row(OP_CLEAR));
    stim_rows.push_back(op_row(OP_SPARE_6, 3'd5, 3'd5, 8'hFF));
    stim_rows.push_back(op_row(OP_SPARE_7, 3'd2, 3'd1, 8'h55));
    stim_rows.push_back(op_row(OP_STORE, 3'd0, 3'd0, 8'hFF));
    stim_rows.push_back(op_row(OP_STORE, 3'd0, 3'd7, 8'h01));
    stim_rows.push_back(op_row(OP_STORE, 3'd7, 3'd7, 8'h80));
    stim_rows.push_back(op_row(OP_STORE, 3'd3, 3'd4, 8'hA5));
    stim_rows.push_back(op_row(OP_STORE, 3'd1, 3'd2, 8'h3C));
    stim_rows.push_back(op_row(OP_FLUSH));
    stim_rows.push_back(cfg_row(4'd8, 4'd15, 1'b1));
    stim_rows.push_back(op_row(OP_INIT));
    stim_rows.push_back(op_row(OP_FLUSH));
    stim_rows.push_back(op_row(OP_STORE, 3'd7, 3'd7, 8'h7F));
    stim_rows.push_back(cfg_row(4'd0, 4'd9, 1'b0));
    stim_rows.push_back(op_row(OP_INIT));
    stim_rows.push_back(op_row(OP_FLUSH));
    stim_rows.push_back(typed_row(OP_TEST_ON, REG_TEST, TEST_ENABLE));
    stim_rows.push_back(cfg_row(4'd15, 4'd10, 1'b1));
    stim_rows.push_back(op_row(OP_FLUSH));
    stim_rows.push_back(op_row(OP_INIT));
    stim_rows.push_back(cfg_row(4'd1, 4'd9, 1'b0));
    stim_rows.push_back(op_row(OP_INIT));
    stim_rows.push_back(op_row(OP_CLEAR));
    stim_rows.push_back(typed_row(OP_TEST_OFF, REG_TEST, DATA_ZERO));

    foreach (stim_rows[k]) begin
      if (stim_rows[k].is_cfg) set_config(stim_rows[k].chain, stim_rows[k].bright,
                                          stim_rows[k].invert);
      else send_op(stim_rows[k]);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: set_config(4'd8, 4'd15, 1'b1);
        1: set_config(4'd1, 4'd0, 1'b0);
        default: begin
          chain = ($urandom_range(0, 3) == 0) ? CHAIN_W'($urandom_range(0, 15)) :
                                                CHAIN_W'($urandom_range(1, 8));
          set_config(chain, BRIGHT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        end
      endcase
      src_fast  = (p == 1 || p == 4);
      sink_fast = (p == 1 || p == 3);
      counted   = 0;
      paused    = 1'b0;
      while (counted < OPS_PER_PHASE) begin
        if (p == 2 && counted == OPS_PER_PHASE / 2 && !paused) begin
          drain();
          paused = 1'b1;
        end
        row = rand_row();
        send_op(row);
        if (row.op != OP_SPARE_6 && row.op != OP_SPARE_7) counted++;
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d operations (%0d flushes, %0d inits) under %0d register settings",
             ops_sent, flushes_sent, inits_sent, settings_used);
    $display("Compared %0d command words, %0d mismatches", words_seen, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
